@@ rtl/fcv_pkg.sv @@
package fcv_pkg;

  localparam int unsigned CordicSteps = 20;
  localparam int unsigned CordicIdxW  = 5;
  localparam int unsigned CordicW     = 34;
  localparam int unsigned TrigW       = 18;
  localparam int unsigned CompW       = 20;

  localparam logic signed [CordicW-1:0] CordicGain = 34'sd652032874;

  // turn: floor((amount + 180) / 360), biased positive by 360 * 5965233;
  // drop three bits, then divide by 45 with ceil(2^36 / 45) and a shift by 36
  localparam int unsigned DivW       = 33;
  localparam int unsigned DivCntW    = 1;
  localparam int unsigned DivProdW   = 61;
  localparam int unsigned TurnRecipShift = 36;
  localparam logic [DivW-1:0] TurnOffset = 33'd2147484060;
  localparam logic [15:0]    TurnBias   = 16'd1457;
  localparam logic [30:0]    TurnRecip  = 31'd1527099484;

  function automatic logic signed [CordicW-1:0] atan_lut(input logic [CordicIdxW-1:0] idx);
    logic signed [CordicW-1:0] v;
    unique case (idx)
      5'd0:  v = 34'sh020000000;
      5'd1:  v = 34'sh012E4051E;
      5'd2:  v = 34'sh009FB385B;
      5'd3:  v = 34'sh0051111D4;
      5'd4:  v = 34'sh0028B0D43;
      5'd5:  v = 34'sh00145D7E1;
      5'd6:  v = 34'sh000A2F61E;
      5'd7:  v = 34'sh000517C55;
      5'd8:  v = 34'sh00028BE53;
      5'd9:  v = 34'sh000145F2F;
      5'd10: v = 34'sh0000A2F98;
      5'd11: v = 34'sh0000517CC;
      5'd12: v = 34'sh000028BE6;
      5'd13: v = 34'sh0000145F3;
      5'd14: v = 34'sh00000A2FA;
      5'd15: v = 34'sh00000517D;
      5'd16: v = 34'sh0000028BE;
      5'd17: v = 34'sh00000145F;
      5'd18: v = 34'sh000000A30;
      5'd19: v = 34'sh000000518;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/free_fly_camera_view_unit.sv @@
// Free-fly camera view unit. Holds the camera position and 16-bit yaw and pitch phases;
// each input beat (move left, move front, turn yaw, turn pitch) updates that state,
// clamps the position to the bound radius cube and then delivers the 4x4 look-at view
// matrix as four output beats, rows 0 to 3, last on row 3. The block takes one command
// at a time. The work is three passes of the shared 20-step CORDIC unit (yaw, pitch,
// yaw plus a quarter turn), seventeen steps of the shared 32x20 multiplier-accumulator
// and, for turns, a reciprocal multiply that divides degrees by 360.
// bound_radius is written through cfg_wr_en_i/cfg_wr_data_i; the user must write it
// only while the block is idle, the block itself does not enforce this.
module free_fly_camera_view_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_wr_en_i,
  input  logic [30:0]        cfg_wr_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         kind_i,
  input  logic signed [31:0] amount_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         row_index_o,
  output logic signed [31:0] col_zero_o,
  output logic signed [31:0] col_one_o,
  output logic signed [31:0] col_two_o,
  output logic signed [31:0] col_three_o,
  output logic               last_o
);

  localparam int unsigned CW = fcv_pkg::CompW;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_CGO  = 3'd2;
  localparam logic [2:0] ST_CWT  = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_ACC  = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  localparam logic [1:0] K_LEFT  = 2'd0;
  localparam logic [1:0] K_FRONT = 2'd1;
  localparam logic [1:0] K_YAW   = 2'd2;

  // multiply-accumulate program steps
  localparam logic [4:0] MS_FX  = 5'd0;
  localparam logic [4:0] MS_FZ  = 5'd1;
  localparam logic [4:0] MS_PX  = 5'd2;
  localparam logic [4:0] MS_PY  = 5'd3;
  localparam logic [4:0] MS_PZ  = 5'd4;
  localparam logic [4:0] MS_UX  = 5'd5;
  localparam logic [4:0] MS_UY0 = 5'd6;
  localparam logic [4:0] MS_UY1 = 5'd7;
  localparam logic [4:0] MS_UZ  = 5'd8;
  localparam logic [4:0] MS_T00 = 5'd9;
  localparam logic [4:0] MS_T01 = 5'd10;
  localparam logic [4:0] MS_T10 = 5'd11;
  localparam logic [4:0] MS_T11 = 5'd12;
  localparam logic [4:0] MS_T12 = 5'd13;
  localparam logic [4:0] MS_T20 = 5'd14;
  localparam logic [4:0] MS_T21 = 5'd15;
  localparam logic [4:0] MS_T22 = 5'd16;

  localparam logic [3:0] D_NONE = 4'd0;
  localparam logic [3:0] D_FX   = 4'd1;
  localparam logic [3:0] D_FZ   = 4'd2;
  localparam logic [3:0] D_PX   = 4'd3;
  localparam logic [3:0] D_PY   = 4'd4;
  localparam logic [3:0] D_PZ   = 4'd5;
  localparam logic [3:0] D_UX   = 4'd6;
  localparam logic [3:0] D_UY   = 4'd7;
  localparam logic [3:0] D_UZ   = 4'd8;
  localparam logic [3:0] D_T0   = 4'd9;
  localparam logic [3:0] D_T1   = 4'd10;
  localparam logic [3:0] D_T2   = 4'd11;

  logic [2:0]  state_q, state_d;
  logic [1:0]  kind_q;
  logic signed [31:0] amt_q;
  logic [30:0] bound_q;
  logic signed [31:0] px_q, py_q, pz_q;
  logic [15:0] yaw_q, pitch_q;
  logic [fcv_pkg::DivW-1:0]     dnum_q;
  logic [fcv_pkg::DivProdW-1:0] dprod_q;
  logic [fcv_pkg::DivCntW-1:0]  dcnt_q;
  logic [1:0]  csel_q;
  logic [4:0]  mstep_q;
  logic [1:0]  row_q;
  logic signed [CW-1:0] sy_q, cy_q, sp_q, cp_q, lx_q, lz_q;
  logic signed [CW-1:0] fx_q, fz_q, ux_q, uy_q, uz_q;
  logic signed [31:0]   t0_q, t1_q, t2_q;
  logic signed [51:0]   prod_q;
  logic signed [55:0]   acc_q;

  logic               cstart, cdone;
  logic [15:0]        cphase;
  logic signed [fcv_pkg::TrigW-1:0] csin, ccos;

  logic signed [31:0]   mul_a;
  logic signed [CW-1:0] mul_b;
  logic                 m_sub, m_first, m_neg;
  logic [3:0]           m_dst;
  logic signed [55:0]   prod_x, sum_w, sum_r;
  logic signed [39:0]   rnd, rnd_s, mv, bnd, pos_sel;
  logic signed [31:0]   mv_c, sat_c;
  logic signed [CW-1:0] cmp_c;
  logic [15:0]          turn_q16;

  fcv_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cstart),
    .phase_i (cphase),
    .done_o  (cdone),
    .sin_o   (csin),
    .cos_o   (ccos)
  );

  assign cstart = (state_q == ST_CGO);
  always_comb begin
    unique case (csel_q)
      2'd0:    cphase = yaw_q;
      2'd1:    cphase = pitch_q;
      default: cphase = yaw_q + 16'd16384;
    endcase
  end

  // step program of the shared multiplier
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    m_sub   = 1'b0;
    m_first = 1'b0;
    m_neg   = 1'b0;
    m_dst   = D_NONE;
    unique case (mstep_q)
      MS_FX:  begin mul_a = 32'(cp_q); mul_b = sy_q; m_first = 1'b1; m_dst = D_FX; end
      MS_FZ:  begin mul_a = 32'(cp_q); mul_b = cy_q; m_first = 1'b1; m_dst = D_FZ; end
      MS_PX:  begin
        mul_a = amt_q; m_first = 1'b1; m_dst = D_PX;
        mul_b = (kind_q == K_LEFT) ? lx_q : ((kind_q == K_FRONT) ? fx_q : '0);
      end
      MS_PY:  begin
        mul_a = amt_q; m_first = 1'b1; m_dst = D_PY;
        mul_b = (kind_q == K_FRONT) ? sp_q : '0;
      end
      MS_PZ:  begin
        mul_a = amt_q; m_first = 1'b1; m_dst = D_PZ;
        mul_b = (kind_q == K_LEFT) ? lz_q : ((kind_q == K_FRONT) ? fz_q : '0);
      end
      MS_UX:  begin mul_a = 32'(sp_q); mul_b = lz_q; m_first = 1'b1; m_dst = D_UX; end
      MS_UY0: begin mul_a = 32'(fz_q); mul_b = lx_q; m_first = 1'b1; end
      MS_UY1: begin mul_a = 32'(fx_q); mul_b = lz_q; m_sub = 1'b1; m_dst = D_UY; end
      MS_UZ:  begin
        mul_a = 32'(sp_q); mul_b = lx_q; m_first = 1'b1; m_neg = 1'b1; m_dst = D_UZ;
      end
      MS_T00: begin mul_a = px_q; mul_b = lx_q; m_sub = 1'b1; m_first = 1'b1; end
      MS_T01: begin
        mul_a = pz_q; mul_b = lz_q; m_sub = 1'b1; m_neg = 1'b1; m_dst = D_T0;
      end
      MS_T10: begin mul_a = px_q; mul_b = ux_q; m_first = 1'b1; end
      MS_T11: begin mul_a = py_q; mul_b = uy_q; end
      MS_T12: begin mul_a = pz_q; mul_b = uz_q; m_neg = 1'b1; m_dst = D_T1; end
      MS_T20: begin mul_a = px_q; mul_b = fx_q; m_first = 1'b1; end
      MS_T21: begin mul_a = py_q; mul_b = sp_q; end
      MS_T22: begin mul_a = pz_q; mul_b = fz_q; m_dst = D_T2; end
      default: ;
    endcase
  end

  assign prod_x = 56'(prod_q);
  assign sum_w  = (m_first ? 56'sd0 : acc_q) + (m_sub ? -prod_x : prod_x);
  assign sum_r  = sum_w + 56'sd32768;
  assign rnd    = sum_r[55:16];
  assign rnd_s  = m_neg ? -rnd : rnd;
  assign cmp_c  = rnd_s[CW-1:0];

  always_comb begin
    unique case (m_dst)
      D_PX:    pos_sel = 40'(px_q);
      D_PY:    pos_sel = 40'(py_q);
      default: pos_sel = 40'(pz_q);
    endcase
  end

  // move then clamp into the bound cube
  assign bnd = 40'({9'd0, bound_q});
  assign mv  = pos_sel + rnd;
  always_comb begin
    mv_c = mv[31:0];
    if (mv > bnd)  mv_c = bnd[31:0];
    if (mv < -bnd) mv_c = -bnd[31:0];
    sat_c = rnd_s[31:0];
    if (rnd_s > 40'sd2147483647)  sat_c = 32'sh7FFFFFFF;
    if (rnd_s < -40'sd2147483648) sat_c = 32'sh80000000;
  end

  // divide by 360: the reciprocal product is registered first, then the turn is applied from it
  assign turn_q16 = dprod_q[fcv_pkg::TurnRecipShift +: 16] - fcv_pkg::TurnBias;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = kind_i[1] ? ST_DIV : ST_CGO;
      ST_DIV:  if (dcnt_q == fcv_pkg::DivCntW'(1)) state_d = ST_CGO;
      ST_CGO:  state_d = ST_CWT;
      ST_CWT:  if (cdone) state_d = (csel_q == 2'd2) ? ST_MUL : ST_CGO;
      ST_MUL:  state_d = ST_ACC;
      ST_ACC:  state_d = (mstep_q == MS_T22) ? ST_OUT : ST_MUL;
      ST_OUT:  if (!out_stall_i && row_q == 2'd3) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      bound_q <= 31'd655360;
      px_q    <= '0;
      py_q    <= '0;
      pz_q    <= '0;
      yaw_q   <= 16'd32768;
      pitch_q <= '0;
      dcnt_q  <= '0;
      csel_q  <= '0;
      mstep_q <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_wr_en_i) bound_q <= cfg_wr_data_i;
      unique case (state_q)
        ST_IDLE: begin
          dcnt_q  <= '0;
          csel_q  <= '0;
          mstep_q <= MS_FX;
          row_q   <= '0;
        end
        ST_DIV: begin
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == fcv_pkg::DivCntW'(1)) begin
            if (kind_q == K_YAW) yaw_q <= yaw_q + turn_q16;
            else                 pitch_q <= pitch_q + turn_q16;
          end
        end
        ST_CWT: if (cdone) csel_q <= csel_q + 1'b1;
        ST_ACC: begin
          mstep_q <= mstep_q + 1'b1;
          if (m_dst == D_PX) px_q <= mv_c;
          if (m_dst == D_PY) py_q <= mv_c;
          if (m_dst == D_PZ) pz_q <= mv_c;
        end
        ST_OUT: if (!out_stall_i) row_q <= row_q + 1'b1;
        default: ;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      kind_q <= kind_i;
      amt_q  <= amount_i;
      dnum_q <= 33'({amount_i[31], amount_i}) + fcv_pkg::TurnOffset;
    end
    if (state_q == ST_DIV && dcnt_q == '0)
      dprod_q <= dnum_q[fcv_pkg::DivW-1:3] * fcv_pkg::TurnRecip;
    if (state_q == ST_CWT && cdone) begin
      unique case (csel_q)
        2'd0:    begin sy_q <= CW'(csin); cy_q <= CW'(ccos); end
        2'd1:    begin sp_q <= CW'(csin); cp_q <= CW'(ccos); end
        default: begin lx_q <= CW'(csin); lz_q <= CW'(ccos); end
      endcase
    end
    if (state_q == ST_MUL) prod_q <= mul_a * mul_b;
    if (state_q == ST_ACC) begin
      acc_q <= sum_w;
      if (m_dst == D_FX) fx_q <= cmp_c;
      if (m_dst == D_FZ) fz_q <= cmp_c;
      if (m_dst == D_UX) ux_q <= cmp_c;
      if (m_dst == D_UY) uy_q <= cmp_c;
      if (m_dst == D_UZ) uz_q <= cmp_c;
      if (m_dst == D_T0) t0_q <= sat_c;
      if (m_dst == D_T1) t1_q <= sat_c;
      if (m_dst == D_T2) t2_q <= sat_c;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign row_index_o = row_q;
  assign last_o      = (row_q == 2'd3);

  always_comb begin
    unique case (row_q)
      2'd0: begin
        col_zero_o  = 32'(-lx_q);
        col_one_o   = '0;
        col_two_o   = 32'(-lz_q);
        col_three_o = t0_q;
      end
      2'd1: begin
        col_zero_o  = 32'(ux_q);
        col_one_o   = 32'(uy_q);
        col_two_o   = 32'(uz_q);
        col_three_o = t1_q;
      end
      2'd2: begin
        col_zero_o  = 32'(-fx_q);
        col_one_o   = 32'(-sp_q);
        col_two_o   = 32'(-fz_q);
        col_three_o = t2_q;
      end
      default: begin
        col_zero_o  = '0;
        col_one_o   = '0;
        col_two_o   = '0;
        col_three_o = 32'sd65536;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("output beat while input open");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_o) |=> !out_valid_o)
    else $error("beat after last row");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (in_stall_o && !out_valid_o))
    else $error("accept did not start work");
  a_pos_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(cfg_wr_en_i)) |->
      ($signed({1'b0, px_q}) <= $signed({2'b0, bound_q}) || px_q[31] == 1'b1))
    else $error("position above bound");
`endif

endmodule

@@ rtl/fcv_cordic.sv @@
module fcv_cordic (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [15:0]                      phase_i,
  output logic                             done_o,
  output logic signed [fcv_pkg::TrigW-1:0] sin_o,
  output logic signed [fcv_pkg::TrigW-1:0] cos_o
);

  logic signed [fcv_pkg::CordicW-1:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic [fcv_pkg::CordicIdxW-1:0]     idx_q, idx_d;
  logic                               busy_q, busy_d, done_q, done_d, neg_q, neg_d;
  logic                               fold;
  logic [15:0]                        fphase;
  logic signed [fcv_pkg::CordicW-1:0] dx, dy, at;
  logic signed [fcv_pkg::CordicW-1:0] xr, yr;
  logic signed [19:0]                 xs, ys;
  logic signed [fcv_pkg::TrigW-1:0]   xc, yc;

  assign fold   = (phase_i[15:14] == 2'd1) || (phase_i[15:14] == 2'd2);
  assign fphase = {phase_i[15] ^ fold, phase_i[14:0]};
  assign dx     = y_q >>> idx_q;
  assign dy     = x_q >>> idx_q;
  assign at     = fcv_pkg::atan_lut(idx_q);

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    idx_d  = idx_q;
    busy_d = busy_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    if (start_i) begin
      x_d    = fcv_pkg::CordicGain;
      y_d    = '0;
      z_d    = {{2{fphase[15]}}, fphase, 16'd0};
      idx_d  = '0;
      busy_d = 1'b1;
      neg_d  = fold;
    end else if (busy_q) begin
      if (!z_q[fcv_pkg::CordicW-1]) begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - at;
      end else begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + at;
      end
      idx_d = idx_q + 1'b1;
      if (idx_q == fcv_pkg::CordicIdxW'(fcv_pkg::CordicSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    z_q   <= z_d;
    neg_q <= neg_d;
  end

  // Q30 to Q16.16 with rounding, then clamp to one
  assign xr = (x_q + 34'sd8192) >>> 14;
  assign yr = (y_q + 34'sd8192) >>> 14;
  assign xs = xr[19:0];
  assign ys = yr[19:0];

  always_comb begin
    xc = xs[fcv_pkg::TrigW-1:0];
    yc = ys[fcv_pkg::TrigW-1:0];
    if (xs > 20'sd65536)  xc = 18'sd65536;
    if (xs < -20'sd65536) xc = -18'sd65536;
    if (ys > 20'sd65536)  yc = 18'sd65536;
    if (ys < -20'sd65536) yc = -18'sd65536;
  end

  assign done_o = done_q;
  assign cos_o  = neg_q ? -xc : xc;
  assign sin_o  = neg_q ? -yc : yc;

endmodule
